// ----- rtl/lcd_nibble_expander_sequencer_defines.svh -----
// assertion macros for the lcd nibble expander sequencer checker
`ifndef LCD_NIBBLE_EXPANDER_SEQUENCER_DEFINES_SVH
`define LCD_NIBBLE_EXPANDER_SEQUENCER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LCDX_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lcdx assertion failed");

// next-cycle implication, disabled during reset
`define LCDX_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lcdx assertion failed");

`endif

// ----- rtl/lcdx_pkg.sv -----
// shared types, codes and constants of the lcd nibble expander sequencer
package lcdx_pkg;

    localparam int OP_W     = 3;
    localparam int ADDR7_W  = 7;
    localparam int PADDR_W  = 3;

    localparam logic [OP_W-1:0] OP_INIT      = 3'd0;
    localparam logic [OP_W-1:0] OP_COMMAND   = 3'd1;
    localparam logic [OP_W-1:0] OP_DATA      = 3'd2;
    localparam logic [OP_W-1:0] OP_BACKLIGHT = 3'd3;
    localparam logic [OP_W-1:0] OP_CURSOR    = 3'd4;

    localparam logic [PADDR_W-1:0] CFG_EXPANDER_ADDRESS = 3'd0;
    localparam logic [ADDR7_W-1:0] EXPANDER_ADDRESS_RST = 7'd39;

    localparam logic [7:0] PIN_RS = 8'h01;
    localparam logic [7:0] PIN_RW = 8'h02;
    localparam logic [7:0] PIN_E  = 8'h04;
    localparam logic [7:0] PIN_BL = 8'h08;

    localparam logic [7:0] ADDR_LINE1   = 8'h40;
    localparam logic [7:0] CMD_SET_ADDR = 8'h80;

    localparam int INIT_LEN = 7;
    localparam int IDX_W    = 3;
    localparam int Q_DEPTH  = 2;
    localparam int QPTR_W   = $clog2(Q_DEPTH);
    localparam int QCNT_W   = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        JOB_INIT,
        JOB_BYTE,
        JOB_BACKLIGHT
    } job_kind_t;

    typedef struct packed {
        job_kind_t  kind;
        logic       is_data;
        logic [7:0] data;
        logic       bl_on;
    } job_t;

    function automatic logic [7:0] init_byte(input logic [IDX_W-1:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h03;
            3'd1:    b = 8'h03;
            3'd2:    b = 8'h03;
            3'd3:    b = 8'h02;
            3'd4:    b = 8'h20 | 8'h08;
            3'd5:    b = 8'h01;
            3'd6:    b = 8'h0C;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ----- rtl/lcd_nibble_expander_sequencer.sv -----
// top level of the lcd nibble expander sequencer
//
// request channel s_*: one word per display request (init, command byte,
// data byte, backlight, set cursor); unknown op codes are taken and dropped.
// result channel m_*: one word per expander port write, with the bus address
// and a last flag on the final write of each request.
// config: apb register at offset 0 holds the 7-bit expander address (reset 39).
// byte ops give 7 writes, backlight 1, init 51; one port-write sequencer
// emits one write per cycle unless m_ready stalls it and loads the next job
// with the last write of the current one, and drives an output register.
// a two-entry job queue lets requests be taken while the sequencer works.
// a stalled m_ready holds the output register and the sequencer; requests
// keep being taken until the queue fills.
// reset clears the port image, the queue and the output register.
module lcd_nibble_expander_sequencer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lcdx_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [lcdx_pkg::OP_W-1:0]     s_op,
    input  logic [7:0]                    s_value,
    input  logic                          s_backlight_on,
    input  logic                          s_line,
    input  logic [5:0]                    s_column,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_port_byte,
    output logic [lcdx_pkg::ADDR7_W-1:0]  m_target_address,
    output logic                          m_last
);
    import lcdx_pkg::*;

    logic [ADDR7_W-1:0] exp_addr_reg;
    logic               q_full, q_push, q_valid, q_pop;
    job_t               push_job, pop_job;

    assign pready = 1'b1;
    assign prdata = (paddr == CFG_EXPANDER_ADDRESS) ? {25'd0, exp_addr_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_addr_reg <= EXPANDER_ADDRESS_RST;
        end else if (psel && penable && pwrite && pready &&
                     (paddr == CFG_EXPANDER_ADDRESS)) begin
            exp_addr_reg <= pwdata[ADDR7_W-1:0];
        end
    end

    lcdx_front u_front (
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_value        (s_value),
        .s_backlight_on (s_backlight_on),
        .s_line         (s_line),
        .s_column       (s_column),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_job          (push_job)
    );

    lcdx_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_job  (push_job),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop       (q_pop),
        .pop_job   (pop_job)
    );

    lcdx_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .expander_address (exp_addr_reg),
        .q_valid          (q_valid),
        .q_pop            (q_pop),
        .q_job            (pop_job),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_port_byte      (m_port_byte),
        .m_target_address (m_target_address),
        .m_last           (m_last)
    );

endmodule

// ----- rtl/lcdx_front.sv -----
// front end: accepts request words and turns them into sequencer jobs
module lcdx_front (
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [lcdx_pkg::OP_W-1:0] s_op,
    input  logic [7:0]              s_value,
    input  logic                    s_backlight_on,
    input  logic                    s_line,
    input  logic [5:0]              s_column,
    input  logic                    q_full,
    output logic                    q_push,
    output lcdx_pkg::job_t          q_job
);
    import lcdx_pkg::*;

    logic       op_known;
    logic [7:0] cursor_cmd;

    assign s_ready    = !q_full;
    assign cursor_cmd = CMD_SET_ADDR + (s_line ? ADDR_LINE1 : 8'h00) + {2'b00, s_column};

    always_comb begin
        op_known        = 1'b1;
        q_job.kind      = JOB_BYTE;
        q_job.is_data   = 1'b0;
        q_job.data      = s_value;
        q_job.bl_on     = s_backlight_on;
        unique case (s_op)
            OP_INIT: begin
                q_job.kind = JOB_INIT;
                q_job.data = init_byte(3'd0);
            end
            OP_COMMAND: begin
                q_job.kind = JOB_BYTE;
            end
            OP_DATA: begin
                q_job.kind    = JOB_BYTE;
                q_job.is_data = 1'b1;
            end
            OP_BACKLIGHT: begin
                q_job.kind = JOB_BACKLIGHT;
            end
            OP_CURSOR: begin
                q_job.kind = JOB_BYTE;
                q_job.data = cursor_cmd;
            end
            default: begin
                op_known = 1'b0;
            end
        endcase
    end

    // unknown ops are taken and dropped
    assign q_push = s_valid && s_ready && op_known;

endmodule

// ----- rtl/lcdx_queue.sv -----
// short job queue between front end and sequencer
module lcdx_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  lcdx_pkg::job_t push_job,
    output logic           full,
    output logic           pop_valid,
    input  logic           pop,
    output lcdx_pkg::job_t pop_job
);
    import lcdx_pkg::*;

    job_t              mem_reg [Q_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign full      = (cnt_reg == QCNT_W'(Q_DEPTH));
    assign pop_valid = (cnt_reg != '0);
    assign pop_job   = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ----- rtl/lcdx_back.sv -----
// back end: expands jobs into port writes and holds the port image
module lcdx_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [lcdx_pkg::ADDR7_W-1:0] expander_address,
    input  logic                         q_valid,
    output logic                         q_pop,
    input  lcdx_pkg::job_t               q_job,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [7:0]                   m_port_byte,
    output logic [lcdx_pkg::ADDR7_W-1:0] m_target_address,
    output logic                         m_last
);
    import lcdx_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLR,
        ST_RW,
        ST_BYTE,
        ST_BL
    } state_t;

    state_t               state_reg, state_next;
    logic [7:0]           img_reg, img_next;
    logic [2:0]           step_reg, step_next;
    logic [IDX_W-1:0]     bidx_reg, bidx_next;
    logic [7:0]           byte_reg, byte_next;
    logic                 is_data_reg, is_data_next;
    logic                 is_init_reg, is_init_next;
    logic                 bl_reg, bl_next;
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           out_byte_reg, out_byte_next;
    logic [ADDR7_W-1:0]   out_addr_reg, out_addr_next;
    logic                 out_last_reg, out_last_next;

    logic                 active, fire, load;
    logic [7:0]           port_w;
    logic                 last_w;

    assign active = (state_reg != ST_IDLE);
    assign fire   = active && (!out_valid_reg || m_ready);

    // port byte and last flag of the current write
    always_comb begin
        port_w = img_reg;
        last_w = 1'b0;
        unique case (state_reg)
            ST_CLR: port_w = 8'h00;
            ST_RW:  port_w = img_reg & ~PIN_RW;
            ST_BL: begin
                port_w = bl_reg ? (img_reg | PIN_BL) : (img_reg & ~PIN_BL);
                last_w = 1'b1;
            end
            ST_BYTE: begin
                case (step_reg)
                    3'd0:    port_w = is_data_reg ? (img_reg | PIN_RS) : (img_reg & ~PIN_RS);
                    3'd1:    port_w = img_reg | PIN_E;
                    3'd2:    port_w = {byte_reg[7:4], img_reg[3:0]};
                    3'd3:    port_w = img_reg & ~PIN_E;
                    3'd4:    port_w = img_reg | PIN_E;
                    3'd5:    port_w = {byte_reg[3:0], img_reg[3:0]};
                    3'd6:    port_w = img_reg & ~PIN_E;
                    default: port_w = img_reg;
                endcase
                last_w = (step_reg == 3'd6) &&
                         (!is_init_reg || (bidx_reg == IDX_W'(INIT_LEN - 1)));
            end
            default: begin
                port_w = img_reg;
            end
        endcase
    end

    assign load  = q_valid && (!active || (fire && last_w));
    assign q_pop = load;

    always_comb begin
        state_next     = state_reg;
        img_next       = img_reg;
        step_next      = step_reg;
        bidx_next      = bidx_reg;
        byte_next      = byte_reg;
        is_data_next   = is_data_reg;
        is_init_next   = is_init_reg;
        bl_next        = bl_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_byte_next  = out_byte_reg;
        out_addr_next  = out_addr_reg;
        out_last_next  = out_last_reg;

        if (fire) begin
            out_valid_next = 1'b1;
            out_byte_next  = port_w;
            out_addr_next  = expander_address;
            out_last_next  = last_w;
            img_next       = port_w;
            if (state_reg == ST_CLR) begin
                state_next = ST_RW;
            end else if (state_reg == ST_RW) begin
                state_next = ST_BYTE;
                step_next  = 3'd0;
                bidx_next  = '0;
                byte_next  = init_byte('0);
            end else if (last_w) begin
                state_next = ST_IDLE;
            end else if (step_reg == 3'd6) begin
                step_next = 3'd0;
                bidx_next = bidx_reg + 1'b1;
                byte_next = init_byte(bidx_reg + 1'b1);
            end else begin
                step_next = step_reg + 3'd1;
            end
        end

        if (load) begin
            step_next    = 3'd0;
            bidx_next    = '0;
            byte_next    = q_job.data;
            is_data_next = q_job.is_data;
            is_init_next = (q_job.kind == JOB_INIT);
            bl_next      = q_job.bl_on;
            case (q_job.kind)
                JOB_INIT:      state_next = ST_CLR;
                JOB_BACKLIGHT: state_next = ST_BL;
                default:       state_next = ST_BYTE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            img_reg       <= 8'h00;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            img_reg       <= img_next;
            out_valid_reg <= out_valid_next;
        end
        step_reg     <= step_next;
        bidx_reg     <= bidx_next;
        byte_reg     <= byte_next;
        is_data_reg  <= is_data_next;
        is_init_reg  <= is_init_next;
        bl_reg       <= bl_next;
        out_byte_reg <= out_byte_next;
        out_addr_reg <= out_addr_next;
        out_last_reg <= out_last_next;
    end

    assign m_valid          = out_valid_reg;
    assign m_port_byte      = out_byte_reg;
    assign m_target_address = out_addr_reg;
    assign m_last           = out_last_reg;

endmodule

// ----- rtl/lcdx_checker.sv -----
// port-level checker for the lcd nibble expander sequencer, with its bind
`include "lcd_nibble_expander_sequencer_defines.svh"

module lcdx_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       pready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_port_byte,
    input logic [6:0] m_target_address,
    input logic       m_last
);

    `LCDX_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_port_byte) && $stable(m_target_address) && $stable(m_last))
    `LCDX_ASSERT_NOW(a_pready_high, aclk, aresetn, 1'b1, pready)
    `LCDX_ASSERT_NOW(a_last_enable_low, aclk, aresetn, m_valid && m_last, !m_port_byte[2])
    `LCDX_ASSERT_NOW(a_rw_low, aclk, aresetn, m_valid, !m_port_byte[1])

endmodule

bind lcd_nibble_expander_sequencer lcdx_checker u_lcdx_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .pready           (pready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_port_byte      (m_port_byte),
    .m_target_address (m_target_address),
    .m_last           (m_last)
);

// ----- bench/tb_top.sv -----
// self-checking bench for the lcd nibble expander sequencer: request stimulus, port-write checks
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lcdx_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED_MIN = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_MID = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_MAX = 3'd7;

    localparam logic [7:0] LCD_WAKE       = 8'h03;
    localparam logic [7:0] LCD_4BIT       = 8'h02;
    localparam logic [7:0] LCD_FUNC_SET   = 8'h28;
    localparam logic [7:0] DISPLAY_CLEAR  = 8'h01;
    localparam logic [7:0] LCD_DISPLAY_ON = 8'h0C;
    localparam logic [7:0] DATA_PINS      = 8'hF0;

    localparam int RX_ALWAYS     = 0;
    localparam int RX_COIN       = 1;
    localparam int RX_RARE_STALL = 2;
    localparam int RX_PERIODIC   = 3;

    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_TAIL   = 8;

    typedef struct packed {
        logic [7:0]         port_byte;
        logic [ADDR7_W-1:0] target_address;
        logic               last;
    } port_write_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [OP_W-1:0]     s_op = OP_INIT;
    logic [7:0]          s_value = '0;
    logic                s_backlight_on = 1'b0;
    logic                s_line = 1'b0;
    logic [5:0]          s_column = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [7:0]          m_port_byte;
    logic [ADDR7_W-1:0]  m_target_address;
    logic                m_last;

    port_write_t         port_writes_expected[$];
    port_write_t         oldest_write;
    logic [7:0]          port_image_model = '0;
    logic [ADDR7_W-1:0]  expander_address_model = EXPANDER_ADDRESS_RST;
    int                  fail_count = 0;
    int                  burst_left = 1;
    int                  gap_max = 0;
    int                  rx_mode = RX_ALWAYS;
    bit                  hold_req = 1'b0;

    lcd_nibble_expander_sequencer DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_value          (s_value),
        .s_backlight_on   (s_backlight_on),
        .s_line           (s_line),
        .s_column         (s_column),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_port_byte      (m_port_byte),
        .m_target_address (m_target_address),
        .m_last           (m_last)
    );

    always #1 aclk = ~aclk;

    function automatic void emit_port_write();
        port_writes_expected.push_back('{port_image_model, expander_address_model, 1'b0});
    endfunction

    function automatic void drive_pin(input logic [7:0] mask, input logic high);
        if (high) begin
            port_image_model = port_image_model | mask;
        end else begin
            port_image_model = port_image_model & ~mask;
        end
        emit_port_write();
    endfunction

    function automatic void drive_data_nibble(input logic [3:0] nib);
        port_image_model = (port_image_model & ~DATA_PINS) | {nib, 4'h0};
        emit_port_write();
    endfunction

    function automatic void send_lcd_byte(input logic is_data, input logic [7:0] b);
        drive_pin(PIN_RS, is_data);
        drive_pin(PIN_E, 1'b1);
        drive_data_nibble(b[7:4]);
        drive_pin(PIN_E, 1'b0);
        drive_pin(PIN_E, 1'b1);
        drive_data_nibble(b[3:0]);
        drive_pin(PIN_E, 1'b0);
    endfunction

    function automatic void predict_port_writes(input logic [OP_W-1:0] op,
                                                input logic [7:0] value,
                                                input logic bl_on,
                                                input logic line,
                                                input logic [5:0] column);
        int first_new;
        first_new = port_writes_expected.size();
        case (op)
            OP_INIT: begin
                port_image_model = '0;
                emit_port_write();
                drive_pin(PIN_RW, 1'b0);
                send_lcd_byte(1'b0, LCD_WAKE);
                send_lcd_byte(1'b0, LCD_WAKE);
                send_lcd_byte(1'b0, LCD_WAKE);
                send_lcd_byte(1'b0, LCD_4BIT);
                send_lcd_byte(1'b0, LCD_FUNC_SET);
                send_lcd_byte(1'b0, DISPLAY_CLEAR);
                send_lcd_byte(1'b0, LCD_DISPLAY_ON);
            end
            OP_COMMAND: begin
                send_lcd_byte(1'b0, value);
            end
            OP_DATA: begin
                send_lcd_byte(1'b1, value);
            end
            OP_BACKLIGHT: begin
                drive_pin(PIN_BL, bl_on);
            end
            OP_CURSOR: begin
                send_lcd_byte(1'b0, CMD_SET_ADDR + {2'b00, column} + (line ? ADDR_LINE1 : 8'h00));
            end
            default: begin
            end
        endcase
        if (port_writes_expected.size() > first_new) begin
            port_writes_expected[port_writes_expected.size() - 1].last = 1'b1;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_port_writes(s_op, s_value, s_backlight_on, s_line, s_column);
            end
            if (m_valid && m_ready) begin
                if (port_writes_expected.size() == 0) begin
                    $error("unexpected word: port_byte %h target_address %h last %b",
                           m_port_byte, m_target_address, m_last);
                    fail_count++;
                end else begin
                    oldest_write = port_writes_expected.pop_front();
                    if (m_port_byte !== oldest_write.port_byte) begin
                        $error("port_byte: expected %h, actual %h",
                               oldest_write.port_byte, m_port_byte);
                        fail_count++;
                    end
                    if (m_target_address !== oldest_write.target_address) begin
                        $error("target_address: expected %h, actual %h",
                               oldest_write.target_address, m_target_address);
                        fail_count++;
                    end
                    if (m_last !== oldest_write.last) begin
                        $error("last: expected %b, actual %b", oldest_write.last, m_last);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial begin : receiver
        int tick;
        int hold_cnt;
        tick = 0;
        hold_cnt = 0;
        forever begin
            @(posedge aclk);
            tick++;
            if (hold_req) begin
                hold_cnt = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_ready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_COIN:       m_ready <= 1'($urandom_range(0, 1));
                    RX_RARE_STALL: m_ready <= ($urandom_range(0, 7) != 0);
                    RX_PERIODIC:   m_ready <= ((tick % 7) > 2);
                    default:       m_ready <= 1'b1;
                endcase
            end
        end
    end

    task automatic offer_request(input logic [OP_W-1:0] op, input logic [7:0] value,
                                 input logic bl_on, input logic line,
                                 input logic [5:0] column);
        int gap;
        s_valid        <= 1'b1;
        s_op           <= op;
        s_value        <= value;
        s_backlight_on <= bl_on;
        s_line         <= line;
        s_column       <= column;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic offer_random_fields(input logic [OP_W-1:0] op);
        offer_request(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)));
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (port_writes_expected.size() != 0) @(posedge aclk);
        repeat (IDLE_TAIL) @(posedge aclk);
    endtask

    task automatic write_expander_address(input logic [31:0] word);
        logic [31:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_EXPANDER_ADDRESS;
        pwdata  <= word;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        expander_address_model = word[ADDR7_W-1:0];
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback[ADDR7_W-1:0] !== expander_address_model) begin
            $error("expander_address: expected %h, actual %h",
                   expander_address_model, readback[ADDR7_W-1:0]);
            fail_count++;
        end
        @(posedge aclk);
    endtask

    function automatic logic [OP_W-1:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)       return OP_INIT;
        else if (r < 28) return OP_COMMAND;
        else if (r < 60) return OP_DATA;
        else if (r < 72) return OP_BACKLIGHT;
        else if (r < 90) return OP_CURSOR;
        else             return OP_W'($urandom_range(OP_UNUSED_MIN, OP_UNUSED_MAX));
    endfunction

    task automatic send_random_requests(input int count);
        logic [OP_W-1:0] op;
        int sent;
        sent = 0;
        while (sent < count) begin
            op = pick_op();
            offer_random_fields(op);
            if (op <= OP_CURSOR) sent++;
        end
    endtask

    task automatic test_directed();
        rx_mode = RX_RARE_STALL;
        gap_max = 2;
        offer_request(OP_INIT, 8'hFF, 1'b1, 1'b1, 6'h3F);
        offer_request(OP_COMMAND, 8'h00, 1'b1, 1'b1, 6'h3F);
        offer_request(OP_COMMAND, 8'hFF, 1'b0, 1'b0, 6'h00);
        offer_request(OP_COMMAND, DISPLAY_CLEAR, 1'b1, 1'b0, 6'h15);
        offer_request(OP_DATA, 8'h00, 1'b1, 1'b1, 6'h2A);
        offer_request(OP_DATA, 8'hFF, 1'b0, 1'b0, 6'h00);
        offer_request(OP_DATA, 8'hA5, 1'b0, 1'b1, 6'h01);
        offer_request(OP_BACKLIGHT, 8'h00, 1'b1, 1'b0, 6'h00);
        offer_request(OP_DATA, 8'h5A, 1'b0, 1'b0, 6'h3F);
        offer_request(OP_BACKLIGHT, 8'hFF, 1'b1, 1'b1, 6'h3F);
        offer_request(OP_CURSOR, 8'hFF, 1'b0, 1'b0, 6'd0);
        offer_request(OP_CURSOR, 8'h00, 1'b1, 1'b1, 6'd39);
        offer_request(OP_CURSOR, 8'h00, 1'b0, 1'b1, 6'd63);
        offer_request(OP_CURSOR, 8'hFF, 1'b1, 1'b0, 6'd63);
        offer_request(OP_UNUSED_MIN, 8'h3C, 1'b1, 1'b1, 6'h2B);
        offer_request(OP_UNUSED_MID, 8'hC3, 1'b0, 1'b0, 6'h14);
        offer_request(OP_UNUSED_MAX, 8'hFF, 1'b1, 1'b1, 6'h3F);
        offer_request(OP_INIT, 8'h00, 1'b0, 1'b0, 6'h00);
        offer_request(OP_BACKLIGHT, 8'h00, 1'b0, 1'b1, 6'h3F);
        offer_request(OP_DATA, 8'h81, 1'b1, 1'b0, 6'h00);
        wait_idle();
    endtask

    task automatic test_address_extremes();
        write_expander_address($urandom & ~32'h7F);
        rx_mode = RX_COIN;
        gap_max = 4;
        send_random_requests(50);
        wait_idle();
        write_expander_address($urandom | 32'h7F);
        rx_mode = RX_ALWAYS;
        gap_max = 0;
        send_random_requests(50);
        wait_idle();
    endtask

    task automatic test_random_settings();
        int phase;
        for (phase = 0; phase < 4; phase++) begin
            write_expander_address($urandom);
            rx_mode = phase;
            gap_max = (phase == RX_ALWAYS) ? 10 : phase * 3;
            send_random_requests(50);
            wait_idle();
        end
    endtask

    task automatic test_backpressure();
        write_expander_address(($urandom & ~32'h7F) | 32'(EXPANDER_ADDRESS_RST));
        rx_mode = RX_ALWAYS;
        gap_max = 0;
        hold_req = 1'b1;
        repeat (12) begin
            offer_random_fields(($urandom_range(0, 1) != 0) ? OP_COMMAND : OP_DATA);
        end
        wait_idle();
        rx_mode = RX_PERIODIC;
        gap_max = 1;
        send_random_requests(15);
        wait_idle();
        send_random_requests(15);
        wait_idle();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_address_extremes();
        test_random_settings();
        test_backpressure();
        wait_idle();
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
